// File: rtl/core/fasta_pkg.sv
// ----------------------------------------------------------------------------
// fasta_pkg
// Shared constants and codes for the FASTA record parser: character codes,
// word kinds, status codes and the record counter width.
// ----------------------------------------------------------------------------
package fasta_pkg;

  // Width of the saturating record counter.
  localparam int unsigned CountWidth = 32;

  localparam logic [7:0] ChGt    = 8'h3E;  // '>'
  localparam logic [7:0] ChHash  = 8'h23;  // '#'
  localparam logic [7:0] ChLf    = 8'h0A;  // '\n'
  localparam logic [7:0] ChCr    = 8'h0D;  // '\r'
  localparam logic [7:0] ChTab   = 8'h09;  // '\t'
  localparam logic [7:0] ChSpace = 8'h20;  // ' '

  typedef enum logic [1:0] {
    KindNone = 2'd0,
    KindId   = 2'd1,
    KindDesc = 2'd2,
    KindSeq  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StNoMark   = 3'd1,
    StEmptyId  = 3'd2,
    StTrunc    = 3'd3,
    StEmptySeq = 3'd4,
    StHalted   = 3'd5
  } status_e;

endpackage

// File: rtl/core/fasta_record_parser.sv
// ----------------------------------------------------------------------------
// fasta_record_parser
// Parses a FASTA byte stream one word per cycle and tags every kept byte as
// an identifier, description or sequence character, with record counting.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o | byte_value_i, end_of_input_i
//  out     | output    | out_valid_o/out_ready_i | kind_o, char_value_o,
//          |           |                        | record_end_o, status_o,
//          |           |                        | records_done_o
//
//  Each word taken yields exactly one output word in the following cycle.
//  Throughput is one word per cycle unless the output stalls: the parse state
//  updates per word taken; the output register refills in the cycle it empties.
//  A stall on the output side holds in_ready_o low until the result is taken.
//  Reset returns the parser to the file start phase and clears the counter.
// ----------------------------------------------------------------------------
module fasta_record_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          byte_value_i,
  input  logic                end_of_input_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fasta_pkg::kind_e    kind_o,
  output logic [7:0]          char_value_o,
  output logic                record_end_o,
  output fasta_pkg::status_e  status_o,
  output logic [31:0]         records_done_o
);
  import fasta_pkg::*;

  typedef enum logic [2:0] {
    PhStart,
    PhSkip,
    PhId,
    PhDesc,
    PhSeq,
    PhSeqNl,
    PhHalt
  } phase_e;

  phase_e                phase_q, phase_d;
  logic                  id_seen_q, id_seen_d;
  logic                  seq_seen_q, seq_seen_d;
  logic [CountWidth-1:0] count_q, count_d;

  logic    out_valid_q;
  kind_e   kind_q, kind_d;
  logic [7:0] char_q;
  logic    rend_q, rend_d;
  status_e status_q, status_d;
  logic [31:0] done_q;

  logic accept;
  logic is_blank;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Characters dropped from sequence lines.
  assign is_blank = (byte_value_i == ChCr) || (byte_value_i == ChSpace) ||
                    (byte_value_i == ChTab);

  always_comb begin
    phase_d    = phase_q;
    id_seen_d  = id_seen_q;
    seq_seen_d = seq_seen_q;
    count_d    = count_q;
    kind_d     = KindNone;
    rend_d     = 1'b0;
    status_d   = StOk;

    if (phase_q == PhHalt) begin
      status_d = StHalted;
    end else if (end_of_input_i) begin
      phase_d = PhHalt;
      unique case (phase_q) inside
        PhStart: status_d = StNoMark;
        PhSkip:  status_d = StOk;
        PhId, PhDesc: status_d = StTrunc;
        default: begin
          if (seq_seen_q) begin
            rend_d = 1'b1;
            if (count_q != '1) count_d = count_q + 1'b1;
          end else begin
            status_d = StEmptySeq;
          end
        end
      endcase
    end else begin
      unique case (phase_q)
        PhStart: begin
          if (byte_value_i == ChHash) begin
            phase_d = PhSkip;
          end else if (byte_value_i == ChGt) begin
            phase_d    = PhId;
            id_seen_d  = 1'b0;
            seq_seen_d = 1'b0;
          end else begin
            status_d = StNoMark;
            phase_d  = PhHalt;
          end
        end
        PhSkip: begin
          if (byte_value_i == ChLf) phase_d = PhStart;
        end
        PhId: begin
          if (byte_value_i == ChSpace || byte_value_i == ChTab) begin
            if (id_seen_q) phase_d = PhDesc;
          end else if (byte_value_i == ChLf) begin
            if (id_seen_q) begin
              phase_d = PhSeq;
            end else begin
              status_d = StEmptyId;
              phase_d  = PhHalt;
            end
          end else if (byte_value_i != ChCr) begin
            kind_d    = KindId;
            id_seen_d = 1'b1;
          end
        end
        PhDesc: begin
          if (byte_value_i == ChLf) begin
            phase_d = PhSeq;
          end else if (byte_value_i != ChCr && byte_value_i != ChTab) begin
            kind_d = KindDesc;
          end
        end
        PhSeq: begin
          if (byte_value_i == ChLf) begin
            phase_d = PhSeqNl;
          end else if (!is_blank) begin
            kind_d     = KindSeq;
            seq_seen_d = 1'b1;
          end
        end
        PhSeqNl: begin
          // A '>' after a newline closes the record and opens the next; with no sequence, it halts.
          if (byte_value_i == ChGt) begin
            if (seq_seen_q) begin
              rend_d = 1'b1;
              if (count_q != '1) count_d = count_q + 1'b1;
              phase_d    = PhId;
              id_seen_d  = 1'b0;
              seq_seen_d = 1'b0;
            end else begin
              status_d = StEmptySeq;
              phase_d  = PhHalt;
            end
          end else if (byte_value_i != ChLf) begin
            phase_d = PhSeq;
            if (!is_blank) begin
              kind_d     = KindSeq;
              seq_seen_d = 1'b1;
            end
          end
        end
        default: status_d = StHalted;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhStart;
      id_seen_q   <= 1'b0;
      seq_seen_q  <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q    <= phase_d;
        id_seen_q  <= id_seen_d;
        seq_seen_q <= seq_seen_d;
        count_q    <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_d;
      char_q   <= (kind_d != KindNone) ? byte_value_i : 8'h00;
      rend_q   <= rend_d;
      status_q <= status_d;
      done_q   <= 32'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign char_value_o   = char_q;
  assign record_end_o   = rend_q;
  assign status_o       = status_q;
  assign records_done_o = done_q;

`ifndef NO_ASSERTIONS
  // A halted result never carries a character or a completed record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StHalted |-> kind_o == KindNone && !record_end_o)
    else $error("halted result carries data");

  // A completed record is always reported with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_end_o |-> status_o == StOk)
    else $error("record end with error status");

  // Once halted, the parser stays halted until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHalt |=> phase_q == PhHalt)
    else $error("parser left halt without reset");

  // An empty output register never blocks the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");
`endif

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for fasta_record_parser. A byte-level model of the parser predicts
// the tag of every accepted word. The testbench sends header lines, directed
// and random records under several idle and stall mixes and a long output
// hold-off. It ends the stream with one randomly chosen final case and then
// checks the halted behavior.
// ----------------------------------------------------------------------------
module tb;
  import fasta_pkg::*;

  typedef enum logic [2:0] {
    PhStart,
    PhSkip,
    PhId,
    PhDesc,
    PhSeq,
    PhSeqNl,
    PhHalt
  } parse_phase_e;

  typedef enum int {
    EndClean,
    EndMarkerEmptySeq,
    EndEmptyId,
    EndInId,
    EndInDesc,
    EndEmptySeq
  } stream_end_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  char_value;
    logic        record_end;
    status_e     status;
    logic [31:0] records;
  } parse_tag_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] byte_value = 8'h00;
  logic       end_of_input = 1'b0;
  logic       out_ready = 1'b0;

  logic        in_ready;
  logic        out_valid;
  kind_e       kind;
  logic [7:0]  char_value;
  logic        record_end;
  status_e     status;
  logic [31:0] records_done;

  // Parser model state.
  parse_phase_e          phase = PhStart;
  logic                  id_seen = 1'b0;
  logic                  seq_seen = 1'b0;
  logic [CountWidth-1:0] rec_count = '0;

  parse_tag_t tags_due[$];
  int         words_sent = 0;
  int         results_seen = 0;
  int         mismatches = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_req = 0;
  int         hold_len = 0;

  fasta_record_parser DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .byte_value_i  (byte_value),
    .end_of_input_i(end_of_input),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .kind_o        (kind),
    .char_value_o  (char_value),
    .record_end_o  (record_end),
    .status_o      (status),
    .records_done_o(records_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic parse_tag_t predict_tag(input logic [7:0] c, input logic eoi);
    parse_tag_t   t;
    parse_phase_e step;
    t.kind       = KindNone;
    t.char_value = 8'h00;
    t.record_end = 1'b0;
    t.status     = StOk;
    if (phase == PhHalt) begin
      t.status = StHalted;
    end else if (eoi) begin
      case (phase) inside
        PhStart:      t.status = StNoMark;
        PhSkip:       t.status = StOk;
        PhId, PhDesc: t.status = StTrunc;
        default: begin
          if (seq_seen) begin
            t.record_end = 1'b1;
            if (rec_count != '1) rec_count = rec_count + 1'b1;
          end else begin
            t.status = StEmptySeq;
          end
        end
      endcase
      phase = PhHalt;
    end else begin
      step = phase;
      // After a newline in the sequence, '>' closes the record (or halts on an empty sequence) and further
      // newlines keep waiting for it; anything else resumes the sequence.
      if (step == PhSeqNl) begin
        if (c == ChGt) begin
          if (seq_seen) begin
            t.record_end = 1'b1;
            if (rec_count != '1) rec_count = rec_count + 1'b1;
            phase    = PhId;
            id_seen  = 1'b0;
            seq_seen = 1'b0;
          end else begin
            t.status = StEmptySeq;
            phase    = PhHalt;
          end
          step = PhHalt;
        end else if (c == ChLf) begin
          step = PhHalt;
        end else begin
          phase = PhSeq;
          step  = PhSeq;
        end
      end
      case (step)
        PhStart: begin
          if (c == ChHash) begin
            phase = PhSkip;
          end else if (c == ChGt) begin
            phase    = PhId;
            id_seen  = 1'b0;
            seq_seen = 1'b0;
          end else begin
            t.status = StNoMark;
            phase    = PhHalt;
          end
        end
        PhSkip: if (c == ChLf) phase = PhStart;
        PhId: begin
          if (c == ChSpace || c == ChTab) begin
            if (id_seen) phase = PhDesc;
          end else if (c == ChLf) begin
            if (id_seen) begin
              phase = PhSeq;
            end else begin
              t.status = StEmptyId;
              phase    = PhHalt;
            end
          end else if (c != ChCr) begin
            t.kind  = KindId;
            id_seen = 1'b1;
          end
        end
        PhDesc: begin
          if (c == ChLf) phase = PhSeq;
          else if (c != ChCr && c != ChTab) t.kind = KindDesc;
        end
        PhSeq: begin
          if (c == ChLf) begin
            phase = PhSeqNl;
          end else if (c != ChCr && c != ChSpace && c != ChTab) begin
            t.kind   = KindSeq;
            seq_seen = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (t.kind != KindNone) t.char_value = c;
    t.records = rec_count[31:0];
    return t;
  endfunction

  function automatic logic [7:0] rand_byte_not(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c, input logic [7:0] d);
    logic [7:0] v;
    do v = 8'($urandom_range(255)); while (v == a || v == b || v == c || v == d);
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
             results_seen, what, got, want);
    mismatches++;
  endtask

  // Drives one word and holds it until the parser takes it.
  task automatic send_word(input logic [7:0] value, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    byte_value   <= value;
    end_of_input <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tags_due = {tags_due, predict_tag(value, eoi)};
    words_sent++;
  endtask

  // One well-formed record with random content; it always ends on a newline
  // so the next record's '>' closes it.
  task automatic send_record();
    int id_len;
    id_len = $urandom_range(1, 8);
    send_word(ChGt, 1'b0);
    repeat ($urandom_range(0, 2)) send_word($urandom_range(1) ? ChSpace : ChTab, 1'b0);
    repeat (id_len) begin
      if ($urandom_range(7) == 0) send_word(ChCr, 1'b0);
      send_word(rand_byte_not(ChSpace, ChTab, ChLf, ChCr), 1'b0);
    end
    if ($urandom_range(1)) begin
      send_word($urandom_range(1) ? ChSpace : ChTab, 1'b0);
      repeat ($urandom_range(0, 12)) send_word(rand_byte_not(ChLf, ChLf, ChLf, ChLf), 1'b0);
    end
    if ($urandom_range(3) == 0) send_word(ChCr, 1'b0);
    send_word(ChLf, 1'b0);
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(4) == 0) send_word(ChLf, 1'b0);
      send_word(8'h41 + 8'($urandom_range(25)), 1'b0);
      repeat ($urandom_range(0, 15)) begin
        if ($urandom_range(3) == 0) send_word(rand_byte_not(ChLf, ChLf, ChLf, ChLf), 1'b0);
        else send_word(8'h61 + 8'($urandom_range(25)), 1'b0);
      end
      if ($urandom_range(3) == 0) send_word(ChCr, 1'b0);
      send_word(ChLf, 1'b0);
    end
  endtask

  task automatic test_directed_start();
    logic [7:0] text [27] = '{
      ChHash, 8'hFF, ChGt, 8'h00, ChLf,
      ChHash, ChLf,
      ChGt, ChSpace, ChTab, 8'h00, ChCr, 8'hFF, ChTab,
      8'hFF, ChCr, ChTab, ChSpace, ChLf,
      ChSpace, 8'h61, ChCr, ChGt, ChLf, ChLf, ChHash, ChLf
    };
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (text[i]) send_word(text[i], 1'b0);
  endtask

  task automatic test_random_records(input int idle_pct, input int stall_pct);
    int stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at        = words_sent + 300;
    while (words_sent < stop_at) send_record();
  endtask

  // The output side holds off for a long time while words keep coming, so
  // the parser fills up and drops in_ready.
  task automatic test_output_hold();
    int stop_at;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = 300;
    hold_req++;
    stop_at = words_sent + 60;
    while (words_sent < stop_at) send_record();
  endtask

  task automatic test_stream_end();
    stream_end_e how;
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    how = stream_end_e'($urandom_range(EndEmptySeq));
    case (how)
      EndClean: begin
        send_word(ChGt, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(ChLf, 1'b0);
        send_word(8'h43, 1'b0);
        send_word(8'h47, 1'b0);
      end
      EndMarkerEmptySeq: begin
        send_word(ChGt, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(ChLf, 1'b0);
        send_word(ChLf, 1'b0);
        send_word(ChGt, 1'b0);
      end
      EndEmptyId: begin
        send_word(ChGt, 1'b0);
        send_word(ChSpace, 1'b0);
        send_word(ChLf, 1'b0);
      end
      EndInId: begin
        send_word(ChGt, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(8'h62, 1'b0);
      end
      EndInDesc: begin
        send_word(ChGt, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(ChSpace, 1'b0);
        send_word(8'h64, 1'b0);
      end
      default: begin
        send_word(ChGt, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(ChLf, 1'b0);
      end
    endcase
    send_word(8'($urandom_range(255)), 1'b1);
    // Once halted, every word reports the halted status.
    repeat (4) send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
    send_word(ChGt, 1'b0);
    send_word(8'($urandom_range(255)), 1'b1);
    in_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : drive_out_ready
    int hold_ack;
    int hold_left;
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    parse_tag_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tags_due.size() == 0) begin
        report_mismatch("result with none expected", 32'(kind), 32'(KindNone));
      end else begin
        want = tags_due.pop_front();
        if (kind != want.kind) report_mismatch("kind", 32'(kind), 32'(want.kind));
        if (char_value != want.char_value) begin
          report_mismatch("char_value", 32'(char_value), 32'(want.char_value));
        end
        if (record_end != want.record_end) begin
          report_mismatch("record_end", 32'(record_end), 32'(want.record_end));
        end
        if (status != want.status) report_mismatch("status", 32'(status), 32'(want.status));
        if (records_done != want.records) begin
          report_mismatch("records_done", records_done, want.records);
        end
      end
      results_seen++;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_start();
    test_random_records(0, 0);
    test_random_records(61, 0);
    test_random_records(0, 61);
    test_random_records(21, 21);
    test_output_hold();
    test_stream_end();
    while (tags_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && tags_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
